[src/elx_pkg.sv]
// shared types, character codes and token codes of the expression lexer
package elx_pkg;

  // default width of the pending token length counter
  localparam int unsigned LENGTH_BITS_DEF = 8;

  // saturation value of an integer token
  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

  // characters of interest
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_SEMI   = 8'h3B;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_LC_A   = 8'h61;
  localparam logic [7:0] CHAR_LC_Z   = 8'h7A;
  localparam logic [7:0] CHAR_UC_A   = 8'h41;
  localparam logic [7:0] CHAR_UC_Z   = 8'h5A;

  // number of letters in the keyword
  localparam logic [2:0] KW_LEN = 3'd5;

  // token codes
  typedef enum logic [3:0] {
    TOK_EOF     = 4'd0,
    TOK_INT     = 4'd1,
    TOK_PRINT   = 4'd2,
    TOK_UNKNOWN = 4'd3,
    TOK_PLUS    = 4'd4,
    TOK_MINUS   = 4'd5,
    TOK_STAR    = 4'd6,
    TOK_SLASH   = 4'd7,
    TOK_LPAREN  = 4'd8,
    TOK_RPAREN  = 4'd9,
    TOK_SEMI    = 4'd10
  } tok_e;

  // byte classes found by the front end
  typedef enum logic [2:0] {
    CLS_SPACE  = 3'd0,
    CLS_END    = 3'd1,
    CLS_DIGIT  = 3'd2,
    CLS_ALPHA  = 3'd3,
    CLS_SINGLE = 3'd4
  } char_class_e;

  // classified byte as it travels through the queue
  typedef struct packed {
    char_class_e cls;
    tok_e        tok;
    logic [7:0]  code;
  } elx_item_t;

  // letters of the keyword "print" by position
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h70;
      3'd1:    ch = 8'h72;
      3'd2:    ch = 8'h69;
      3'd3:    ch = 8'h6E;
      3'd4:    ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[src/elx_front.sv]
// front end: input handshake and byte classification
module elx_front (
  input  logic               in_valid_i,
  input  logic [7:0]         char_code_i,
  input  logic               full_i,
  output logic               in_ready_o,
  output logic               push_o,
  output elx_pkg::elx_item_t item_o
);

  elx_pkg::char_class_e cls;
  elx_pkg::tok_e        tok;

  // a beat is taken whenever the queue has room
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // classify the byte
  always_comb begin
    cls = elx_pkg::CLS_SINGLE;
    tok = elx_pkg::TOK_UNKNOWN;
    if (char_code_i == elx_pkg::CHAR_SPACE ||
        (char_code_i >= elx_pkg::CHAR_TAB && char_code_i <= elx_pkg::CHAR_CR)) begin
      cls = elx_pkg::CLS_SPACE;
    end else if (char_code_i == elx_pkg::CHAR_NUL) begin
      cls = elx_pkg::CLS_END;
    end else if (char_code_i >= elx_pkg::CHAR_ZERO && char_code_i <= elx_pkg::CHAR_NINE) begin
      cls = elx_pkg::CLS_DIGIT;
    end else if ((char_code_i >= elx_pkg::CHAR_LC_A && char_code_i <= elx_pkg::CHAR_LC_Z) ||
                 (char_code_i >= elx_pkg::CHAR_UC_A && char_code_i <= elx_pkg::CHAR_UC_Z)) begin
      cls = elx_pkg::CLS_ALPHA;
    end else begin
      case (char_code_i)
        elx_pkg::CHAR_PLUS:   tok = elx_pkg::TOK_PLUS;
        elx_pkg::CHAR_MINUS:  tok = elx_pkg::TOK_MINUS;
        elx_pkg::CHAR_STAR:   tok = elx_pkg::TOK_STAR;
        elx_pkg::CHAR_SLASH:  tok = elx_pkg::TOK_SLASH;
        elx_pkg::CHAR_LPAREN: tok = elx_pkg::TOK_LPAREN;
        elx_pkg::CHAR_RPAREN: tok = elx_pkg::TOK_RPAREN;
        elx_pkg::CHAR_SEMI:   tok = elx_pkg::TOK_SEMI;
        default:              tok = elx_pkg::TOK_UNKNOWN;
      endcase
    end
  end

  assign item_o.cls  = cls;
  assign item_o.tok  = tok;
  assign item_o.code = char_code_i;

endmodule

[src/elx_queue.sv]
// two-entry queue between front end and scanner
module elx_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  elx_pkg::elx_item_t item_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               valid_o,
  output elx_pkg::elx_item_t item_o
);

  elx_pkg::elx_item_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = entry_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[src/elx_back.sv]
// back end: token scanner state and output register
module elx_back #(
  parameter int unsigned LengthBits = elx_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  elx_pkg::elx_item_t item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         token_type_o,
  output logic [30:0]        int_value_o,
  output logic [7:0]         token_length_o,
  output logic               last_of_item_o
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_NUM  = 2'd1;
  localparam logic [1:0] MODE_WORD = 2'd2;

  logic [1:0]            mode_q, mode_d;
  logic [30:0]           acc_q, acc_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic [2:0]            kwp_q, kwp_d;
  logic                  kwb_q, kwb_d;

  logic                  out_valid_q, out_valid_d;
  logic [3:0]            type_q, type_d;
  logic [30:0]           value_q, value_d;
  logic [7:0]            olen_q, olen_d;
  logic                  last_q, last_d;

  logic                  out_free, step, in_token, continues, closing;
  logic                  fresh_emits, split, emit;
  logic [3:0]            digit;
  logic [34:0]           prod;
  logic [LengthBits-1:0] len_grown;
  logic [LengthBits+7:0] len_ext;
  logic                  kw_ok;

  // the scanner advances when the output register is free or drains
  assign out_free = !out_valid_q || out_ready_i;
  assign step     = valid_i && out_free;

  assign digit     = item_i.code[3:0];
  assign in_token  = (mode_q == MODE_NUM) || (mode_q == MODE_WORD);
  assign continues = ((mode_q == MODE_NUM) && (item_i.cls == elx_pkg::CLS_DIGIT)) ||
                     ((mode_q == MODE_WORD) && ((item_i.cls == elx_pkg::CLS_DIGIT) ||
                                                (item_i.cls == elx_pkg::CLS_ALPHA)));
  assign closing     = in_token && !continues;
  assign fresh_emits = (item_i.cls == elx_pkg::CLS_END) || (item_i.cls == elx_pkg::CLS_SINGLE);
  // a byte that closes a token and also gives its own token is not popped: the closed token goes first
  assign split = closing && fresh_emits;
  assign emit  = step && (closing || (!in_token && fresh_emits));
  assign pop_o = step && !split;

  // decimal accumulate with saturation
  assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {31'd0, digit};
  assign len_grown = (len_q == {LengthBits{1'b1}}) ? len_q : len_q + 1'b1;
  assign len_ext   = {8'd0, len_q};
  assign kw_ok     = !kwb_q && (kwp_q == elx_pkg::KW_LEN);

  // scanner state update
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    len_d  = len_q;
    kwp_d  = kwp_q;
    kwb_d  = kwb_q;
    if (step) begin
      if (split) begin
        mode_d = MODE_IDLE;
      end else if (continues) begin
        len_d = len_grown;
        if (mode_q == MODE_NUM) begin
          acc_d = (prod > {4'd0, elx_pkg::VALUE_MAX}) ? elx_pkg::VALUE_MAX : prod[30:0];
        end else if (!kwb_q && kwp_q < elx_pkg::KW_LEN &&
                     item_i.code == elx_pkg::kw_char(kwp_q)) begin
          kwp_d = kwp_q + 3'd1;
        end else begin
          kwb_d = 1'b1;
        end
      end else begin
        case (item_i.cls)
          elx_pkg::CLS_DIGIT: begin
            mode_d = MODE_NUM;
            acc_d  = {27'd0, digit};
            len_d  = {{(LengthBits-1){1'b0}}, 1'b1};
          end
          elx_pkg::CLS_ALPHA: begin
            mode_d = MODE_WORD;
            len_d  = {{(LengthBits-1){1'b0}}, 1'b1};
            if (item_i.code == elx_pkg::kw_char(3'd0)) begin
              kwp_d = 3'd1;
              kwb_d = 1'b0;
            end else begin
              kwp_d = 3'd0;
              kwb_d = 1'b1;
            end
          end
          default: begin
            mode_d = MODE_IDLE;
          end
        endcase
      end
    end
  end

  // result selection into the output register
  always_comb begin
    out_valid_d = out_free ? emit : out_valid_q;
    type_d      = type_q;
    value_d     = value_q;
    olen_d      = olen_q;
    last_d      = last_q;
    if (emit) begin
      if (closing) begin
        type_d  = (mode_q == MODE_NUM) ? elx_pkg::TOK_INT
                : (kw_ok ? elx_pkg::TOK_PRINT : elx_pkg::TOK_UNKNOWN);
        value_d = (mode_q == MODE_NUM) ? acc_q : 31'd0;
        olen_d  = len_ext[7:0];
        last_d  = !split;
      end else if (item_i.cls == elx_pkg::CLS_END) begin
        type_d  = elx_pkg::TOK_EOF;
        value_d = 31'd0;
        olen_d  = 8'd0;
        last_d  = 1'b1;
      end else begin
        type_d  = item_i.tok;
        value_d = 31'd0;
        olen_d  = 8'd1;
        last_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      acc_q       <= 31'd0;
      len_q       <= '0;
      kwp_q       <= 3'd0;
      kwb_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      acc_q       <= acc_d;
      len_q       <= len_d;
      kwp_q       <= kwp_d;
      kwb_q       <= kwb_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    type_q  <= type_d;
    value_q <= value_d;
    olen_q  <= olen_d;
    last_q  <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign token_type_o   = type_q;
  assign int_value_o    = value_q;
  assign token_length_o = olen_q;
  assign last_of_item_o = last_q;

endmodule

[src/expression_lexer.sv]
// top level of the streaming expression lexer
//
// Input channel: one source byte per beat on char_code_i (in_valid_i / in_ready_o).
// A zero byte ends the source: it closes a pending token and emits end of file;
// following bytes start a new stream.
// Output channel: one token per beat (out_valid_o / out_ready_i) with type, integer
// value, length and last_of_item_o, which marks the final token caused by a byte.
// An accepted byte is written into the queue; the scanner then takes it from the
// queue head and fills the output register, from which its token is valid.
// The second token of a byte follows once the output register drains.
// Throughput: one byte per cycle while the receiver takes every token. A byte that
// closes a number or word and also gives its own token (an operator, an unknown
// byte or end of file) holds the scanner until both its tokens are out, one a cycle.
// A two-entry queue parts the front end from the scanner; when the receiver
// stalls, the scanner halts, the queue fills and in_ready_o drops after at most
// two more bytes.
// Reset: clears the scanner to idle with no token pending and empties the queue
// and output register.
module expression_lexer #(
  parameter int unsigned LengthBits = elx_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_type_o,
  output logic [30:0] int_value_o,
  output logic [7:0]  token_length_o,
  output logic        last_of_item_o
);

  logic               push, pop, full, q_valid;
  elx_pkg::elx_item_t front_item, head_item;

  elx_front u_front (
    .in_valid_i  (in_valid_i),
    .char_code_i (char_code_i),
    .full_i      (full),
    .in_ready_o  (in_ready_o),
    .push_o      (push),
    .item_o      (front_item)
  );

  elx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  elx_back #(
    .LengthBits (LengthBits)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .item_i         (head_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_type_o   (token_type_o),
    .int_value_o    (int_value_o),
    .token_length_o (token_length_o),
    .last_of_item_o (last_of_item_o)
  );

  // the scanner only pops an entry that is there
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> q_valid)
    else $error("queue popped while empty");

  // end of file is always the last token of its byte and has no length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_type_o == elx_pkg::TOK_EOF |-> last_of_item_o && token_length_o == 8'd0)
    else $error("malformed end of file token");

  // only integer tokens carry a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_type_o != elx_pkg::TOK_INT |-> int_value_o == 31'd0)
    else $error("value on a non-integer token");

  // a token that is not last is followed by the second token of the same byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_item_o |=> out_valid_o)
    else $error("second token of a byte missing");

endmodule
